/* sv/bitmap_first_fit_allocator_macros.svh */
// assertion macros used by the allocator controller
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH

// checked on every clock edge outside reset
`define BFFA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every clock edge, reset included
`define BFFA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

/* sv/bffa_pkg.sv */
package bffa_pkg;

   localparam int NUM_W = 25;
   localparam logic [7:0] FULL_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_OVERLAP = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_INODE_MAP_SECTORS  = 2'd0,
      CSR_SECTOR_MAP_SECTORS = 2'd1,
      CSR_FIRST_DATA_SECTOR  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic        mode;
      logic [15:0] run_length;
   } req_type;

   typedef struct packed {
      logic [NUM_W-1:0] allocated_number;
      status_type       status;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  inode_map_sectors;
      logic [3:0]  sector_map_sectors;
      logic [23:0] first_data_sector;
   } cfg_type;

endpackage

/* sv/bffa_map.sv */
module bffa_map #(
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata
);

   logic [7:0] map_mem [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         map_mem[addr] <= wdata;
      end
      rdata_ff <= map_mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/bffa_ctrl.sv */
`include "bitmap_first_fit_allocator_macros.svh"

module bffa_ctrl #(
   parameter int SECTOR_BYTES = 512,
   parameter int INODE_MAP_SECTORS_MAX = 4,
   parameter int SECTOR_MAP_SECTORS_MAX = 8,
   localparam int IDEPTH = INODE_MAP_SECTORS_MAX * SECTOR_BYTES,
   localparam int SDEPTH = SECTOR_MAP_SECTORS_MAX * SECTOR_BYTES,
   localparam int MDEPTH = (IDEPTH > SDEPTH) ? IDEPTH : SDEPTH,
   localparam int CW = $clog2(MDEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bffa_pkg::req_type req_data,
   input  bffa_pkg::cfg_type cfg,
   output logic              rsp_valid,
   output bffa_pkg::rsp_type rsp_data,
   output logic              imap_we,
   output logic              smap_we,
   output logic [CW-1:0]     map_addr,
   output logic [7:0]        map_wdata,
   input  logic [7:0]        imap_rdata,
   input  logic [7:0]        smap_rdata
);

   localparam int BW = CW + 3;
   localparam int XW = ((BW > 16) ? BW : 16) + 1;
   localparam int NW = bffa_pkg::NUM_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_SETUP,
      ST_CHECK,
      ST_WRITE
   } state_type;

   function automatic logic [2:0] lowest_clear(input logic [7:0] b);
      logic [2:0] idx;
      idx = 3'd0;
      for (int k = 7; k >= 0; k--) begin
         if (!b[k]) idx = 3'(k);
      end
      return idx;
   endfunction

   function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [2:0] hi);
      logic [7:0] m;
      for (int i = 0; i < 8; i++) begin
         m[i] = (3'(i) >= lo) && (3'(i) <= hi);
      end
      return m;
   endfunction

   state_type         state_ff, state_in;
   logic [CW-1:0]     addr_ff, addr_in;
   logic [CW-1:0]     rd_addr_ff, rd_addr_in;
   logic              rd_vld_ff, rd_vld_in;
   logic              mode_ff, mode_in;
   logic [15:0]       count_ff, count_in;
   logic [CW-1:0]     limit_ff, limit_in;
   logic [CW-1:0]     byte_ff, byte_in;
   logic [2:0]        bit_ff, bit_in;
   logic [CW-1:0]     end_byte_ff, end_byte_in;
   logic [2:0]        end_bit_ff, end_bit_in;
   logic [7:0]        d0_ff, d0_in;
   logic [7:0]        dl_ff, dl_in;
   logic [NW-1:0]     number_ff, number_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bffa_pkg::rsp_type rsp_ff, rsp_in;

   logic [7:0]    rdata;
   logic [2:0]    clear_bit;
   logic [7:0]    chk_mask;
   logic [7:0]    wr_mask;
   logic [7:0]    wr_base;
   logic [CW-1:0] ilimit;
   logic [CW-1:0] slimit;
   logic [BW-1:0] start_bit;
   logic [BW-1:0] nbits;
   logic [XW-1:0] remaining;
   logic [XW-1:0] end_bit_idx;

   assign rdata     = mode_ff ? smap_rdata : imap_rdata;
   assign clear_bit = lowest_clear(rdata);
   assign chk_mask  = span_mask((rd_addr_ff == byte_ff) ? bit_ff : 3'd0,
                                (rd_addr_ff == end_byte_ff) ? end_bit_ff : 3'd7);
   assign wr_mask   = span_mask((addr_ff == byte_ff) ? bit_ff : 3'd0,
                                (addr_ff == end_byte_ff) ? end_bit_ff : 3'd7);
   assign wr_base   = (addr_ff == byte_ff) ? d0_ff :
                      (addr_ff == end_byte_ff) ? dl_ff : 8'd0;

   // map sizes in bytes, saturating at the configured maximum
   assign ilimit = (32'(cfg.inode_map_sectors) > 32'(INODE_MAP_SECTORS_MAX)) ?
                   CW'(IDEPTH) : CW'(cfg.inode_map_sectors) * CW'(SECTOR_BYTES);
   assign slimit = (32'(cfg.sector_map_sectors) > 32'(SECTOR_MAP_SECTORS_MAX)) ?
                   CW'(SDEPTH) : CW'(cfg.sector_map_sectors) * CW'(SECTOR_BYTES);

   assign start_bit   = {byte_ff, bit_ff};
   assign nbits       = {limit_ff, 3'b000};
   assign remaining   = XW'(nbits) - XW'(start_bit);
   assign end_bit_idx = XW'(start_bit) + XW'(count_ff) - XW'(1);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      rd_addr_in   = rd_addr_ff;
      rd_vld_in    = 1'b0;
      mode_in      = mode_ff;
      count_in     = count_ff;
      limit_in     = limit_ff;
      byte_in      = byte_ff;
      bit_in       = bit_ff;
      end_byte_in  = end_byte_ff;
      end_bit_in   = end_bit_ff;
      d0_in        = d0_ff;
      dl_in        = dl_ff;
      number_in    = number_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      imap_we      = 1'b0;
      smap_we      = 1'b0;
      map_addr     = addr_ff;
      map_wdata    = 8'd0;

      unique case (state_ff)
         ST_CLEAR: begin
            imap_we = (addr_ff < CW'(IDEPTH));
            smap_we = (addr_ff < CW'(SDEPTH));
            addr_in = addr_ff + CW'(1);
            if (addr_ff == CW'(MDEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               mode_in  = req_data.mode;
               count_in = req_data.run_length;
               limit_in = req_data.mode ? slimit : ilimit;
               addr_in  = '0;
               if (req_data.mode && (req_data.run_length == 16'd0)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{allocated_number: '0, status: bffa_pkg::STATUS_OK};
               end else if ((req_data.mode ? slimit : ilimit) == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{allocated_number: '0, status: bffa_pkg::STATUS_FULL};
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // one byte issued per cycle, data of the previous address checked
            rd_addr_in = addr_ff;
            rd_vld_in  = (addr_ff < limit_ff);
            if (addr_ff < limit_ff) begin
               addr_in = addr_ff + CW'(1);
            end
            if (rd_vld_ff && (rdata != bffa_pkg::FULL_BYTE)) begin
               rd_vld_in = 1'b0;
               byte_in   = rd_addr_ff;
               bit_in    = clear_bit;
               if (!mode_ff) begin
                  imap_we      = 1'b1;
                  map_addr     = rd_addr_ff;
                  map_wdata    = rdata | (8'd1 << clear_bit);
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{allocated_number: NW'({rd_addr_ff, clear_bit}),
                                   status: bffa_pkg::STATUS_OK};
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_SETUP;
               end
            end else if (rd_vld_ff && (rd_addr_ff == limit_ff - CW'(1))) begin
               rd_vld_in    = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in       = '{allocated_number: '0, status: bffa_pkg::STATUS_FULL};
               state_in     = ST_IDLE;
            end
         end

         ST_SETUP: begin
            if (XW'(count_ff) > remaining) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{allocated_number: '0, status: bffa_pkg::STATUS_OVERLAP};
               state_in     = ST_IDLE;
            end else begin
               end_byte_in = end_bit_idx[BW-1:3];
               end_bit_in  = end_bit_idx[2:0];
               addr_in     = byte_ff;
               state_in    = ST_CHECK;
            end
         end

         ST_CHECK: begin
            number_in  = NW'(start_bit) + NW'(cfg.first_data_sector) - NW'(1);
            rd_addr_in = addr_ff;
            rd_vld_in  = (addr_ff <= end_byte_ff);
            if (addr_ff <= end_byte_ff) begin
               addr_in = addr_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               if ((rdata & chk_mask) != 8'd0) begin
                  rd_vld_in    = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{allocated_number: '0,
                                   status: bffa_pkg::STATUS_OVERLAP};
                  state_in     = ST_IDLE;
               end else begin
                  if (rd_addr_ff == byte_ff) begin
                     d0_in = rdata;
                  end
                  if (rd_addr_ff == end_byte_ff) begin
                     // run is clear, keep the edge bytes for the write pass
                     dl_in     = rdata;
                     rd_vld_in = 1'b0;
                     addr_in   = byte_ff;
                     state_in  = ST_WRITE;
                  end
               end
            end
         end

         ST_WRITE: begin
            smap_we   = 1'b1;
            map_wdata = wr_base | wr_mask;
            addr_in   = addr_ff + CW'(1);
            if (addr_ff == end_byte_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{allocated_number: number_ff, status: bffa_pkg::STATUS_OK};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      mode_ff     <= mode_in;
      count_ff    <= count_in;
      limit_ff    <= limit_in;
      byte_ff     <= byte_in;
      bit_ff      <= bit_in;
      end_byte_ff <= end_byte_in;
      end_bit_ff  <= end_bit_in;
      d0_ff       <= d0_in;
      dl_ff       <= dl_in;
      number_ff   <= number_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BFFA_ASSERT(a_wr_states, (imap_we || smap_we) |-> (state_ff == ST_CLEAR || state_ff == ST_SCAN || state_ff == ST_WRITE), "map written outside clear, scan or write")
   `BFFA_ASSERT(a_err_zero, (rsp_valid_ff && rsp_ff.status != bffa_pkg::STATUS_OK) |-> (rsp_ff.allocated_number == '0), "error beat carries a nonzero number")
   `BFFA_ASSERT(a_accept_progress, (start && !busy) |=> (busy || rsp_valid_ff), "accepted request neither started nor answered")
   `BFFA_ASSERT(a_inode_answer, (imap_we && state_ff == ST_SCAN) |=> (rsp_valid_ff && state_ff == ST_IDLE), "inode claim without a result beat")
   `BFFA_ASSERT_ALWAYS(a_clear_quiet, (state_ff == ST_CLEAR && !reset) |-> !rsp_valid_ff, "result beat during the clearing pass")

endmodule

/* sv/bitmap_first_fit_allocator.sv */
// after reset both maps are swept to zero, one byte a cycle over the larger map
// (the larger map is 4096 bytes by default); busy stays high meanwhile
// inode request: the map is scanned from byte 0 to the first byte with a clear bit
// sector run: scan as above, then a setup step, a check pass and a write pass over the run's bytes
// zero sector run length or empty map: result the cycle after start; one request at a time
// each result is a one-cycle rsp_valid beat, the receiver cannot stall it
module bitmap_first_fit_allocator #(
   parameter int SECTOR_BYTES = 512,
   parameter int INODE_MAP_SECTORS_MAX = 4,
   parameter int SECTOR_MAP_SECTORS_MAX = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bffa_pkg::req_type req_data,
   output logic              rsp_valid,
   output bffa_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_wdata
);

   localparam int IDEPTH = INODE_MAP_SECTORS_MAX * SECTOR_BYTES;
   localparam int SDEPTH = SECTOR_MAP_SECTORS_MAX * SECTOR_BYTES;
   localparam int MDEPTH = (IDEPTH > SDEPTH) ? IDEPTH : SDEPTH;
   localparam int CW = $clog2(MDEPTH + 1);
   localparam int IAW = $clog2(IDEPTH);
   localparam int SAW = $clog2(SDEPTH);

   bffa_pkg::cfg_type cfg_ff, cfg_in;

   logic          imap_we;
   logic          smap_we;
   logic [CW-1:0] map_addr;
   logic [7:0]    map_wdata;
   logic [7:0]    imap_rdata;
   logic [7:0]    smap_rdata;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bffa_pkg::CSR_INODE_MAP_SECTORS:  cfg_in.inode_map_sectors  = csr_wdata[2:0];
            bffa_pkg::CSR_SECTOR_MAP_SECTORS: cfg_in.sector_map_sectors = csr_wdata[3:0];
            bffa_pkg::CSR_FIRST_DATA_SECTOR:  cfg_in.first_data_sector  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{inode_map_sectors: 3'd1, sector_map_sectors: 4'd8,
                     first_data_sector: 24'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bffa_ctrl #(
      .SECTOR_BYTES(SECTOR_BYTES),
      .INODE_MAP_SECTORS_MAX(INODE_MAP_SECTORS_MAX),
      .SECTOR_MAP_SECTORS_MAX(SECTOR_MAP_SECTORS_MAX)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .cfg(cfg_ff),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .imap_we(imap_we),
      .smap_we(smap_we),
      .map_addr(map_addr),
      .map_wdata(map_wdata),
      .imap_rdata(imap_rdata),
      .smap_rdata(smap_rdata)
   );

   bffa_map #(.DEPTH(IDEPTH)) u_imap (
      .clock(clock),
      .we(imap_we),
      .addr(map_addr[IAW-1:0]),
      .wdata(map_wdata),
      .rdata(imap_rdata)
   );

   bffa_map #(.DEPTH(SDEPTH)) u_smap (
      .clock(clock),
      .we(smap_we),
      .addr(map_addr[SAW-1:0]),
      .wdata(map_wdata),
      .rdata(smap_rdata)
   );

endmodule

/* tb/sv/bitmap_first_fit_allocator_test.sv */
`timescale 1ns / 100ps

module bitmap_first_fit_allocator_test;

   localparam int SECTOR_BYTES = 512;
   localparam int INODE_SECTORS_MAX = 4;
   localparam int SECTOR_SECTORS_MAX = 8;
   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam bit MODE_INODE = 1'b0;
   localparam bit MODE_SECTOR = 1'b1;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      bit                is_csr;
      bffa_pkg::req_type req;
      logic [1:0]        reg_index;
      logic [23:0]       wdata;
   } job_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   bffa_pkg::req_type req_data = '0;
   logic              rsp_valid;
   bffa_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [23:0]       csr_wdata = '0;

   // stimulus still to be driven, grants still to come
   job_type           work_q[$];
   bffa_pkg::rsp_type expected_grants[$];

   logic req_beat = 1'b0;
   logic csr_beat = 1'b0;
   int   idle_pct = 14;

   // shadow of the allocator state
   logic [7:0]  inode_map [INODE_SECTORS_MAX * SECTOR_BYTES];
   logic [7:0]  sector_map [SECTOR_SECTORS_MAX * SECTOR_BYTES];
   logic [2:0]  inode_sectors = 3'd1;
   logic [3:0]  sector_sectors = 4'd8;
   logic [23:0] data_base = '0;

   int faults = 0;
   int n_inode = 0, n_sector = 0, n_writes = 0;
   int n_granted = 0, n_full = 0, n_overlap = 0;

   bitmap_first_fit_allocator #(
      .SECTOR_BYTES(SECTOR_BYTES),
      .INODE_MAP_SECTORS_MAX(INODE_SECTORS_MAX),
      .SECTOR_MAP_SECTORS_MAX(SECTOR_SECTORS_MAX)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned map_sectors(int unsigned v, int unsigned max);
      return (v > max) ? max : v;
   endfunction

   function automatic bit lowest_clear(bit sector_side, int unsigned nbytes,
                                       output int unsigned pos);
      logic [7:0] byte_val;
      pos = 0;
      for (int unsigned j = 0; j < nbytes; j++) begin
         byte_val = sector_side ? sector_map[j] : inode_map[j];
         if (byte_val != bffa_pkg::FULL_BYTE) begin
            for (int k = 0; k < 8; k++) begin
               if (!byte_val[k]) begin
                  pos = j * 8 + k;
                  return 1'b1;
               end
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic bffa_pkg::rsp_type predict_grant(bffa_pkg::req_type r);
      bffa_pkg::rsp_type g;
      int unsigned       nbytes, nbits, first, b;
      logic [31:0]       sum;
      g.allocated_number = '0;
      g.status = bffa_pkg::STATUS_OK;
      if (r.mode == MODE_INODE) begin
         nbytes = map_sectors(inode_sectors, INODE_SECTORS_MAX) * SECTOR_BYTES;
         if (lowest_clear(1'b0, nbytes, first)) begin
            inode_map[first / 8][first % 8] = 1'b1;
            sum = first;
            g.allocated_number = sum[bffa_pkg::NUM_W-1:0];
         end else begin
            g.status = bffa_pkg::STATUS_FULL;
         end
      end else if (r.run_length != 0) begin
         nbytes = map_sectors(sector_sectors, SECTOR_SECTORS_MAX) * SECTOR_BYTES;
         nbits = nbytes * 8;
         if (!lowest_clear(1'b1, nbytes, first)) begin
            g.status = bffa_pkg::STATUS_FULL;
         end else if (r.run_length > nbits - first) begin
            g.status = bffa_pkg::STATUS_OVERLAP;
         end else begin
            for (b = first; b < first + r.run_length; b++)
               if (sector_map[b / 8][b % 8]) g.status = bffa_pkg::STATUS_OVERLAP;
            if (g.status == bffa_pkg::STATUS_OK) begin
               for (b = first; b < first + r.run_length; b++)
                  sector_map[b / 8][b % 8] = 1'b1;
               // wraps modulo the number width when the run starts at bit 0
               sum = first + data_base - 1;
               g.allocated_number = sum[bffa_pkg::NUM_W-1:0];
            end
         end
      end
      return g;
   endfunction

   task automatic queue_request(bit mode, int unsigned len);
      job_type job;
      job.is_csr = 1'b0;
      job.req.mode = mode;
      job.req.run_length = len[15:0];
      job.reg_index = '0;
      job.wdata = '0;
      work_q.push_back(job);
   endtask

   task automatic queue_write(logic [1:0] idx, logic [23:0] val);
      job_type job;
      job.is_csr = 1'b1;
      job.req = '0;
      job.reg_index = idx;
      job.wdata = val;
      work_q.push_back(job);
   endtask

   // block idle and nothing outstanding
   task automatic wait_idle();
      do @(posedge clock);
      while (work_q.size() != 0 || start || csr_valid || expected_grants.size() != 0
             || busy);
   endtask

   // driver
   always @(negedge clock) begin
      job_type           job;
      logic              start_n, csr_valid_n;
      bffa_pkg::req_type req_n;
      logic [1:0]        idx_n;
      logic [23:0]       wdata_n;
      start_n = start && !req_beat;
      csr_valid_n = csr_valid && !csr_beat;
      req_n = req_data;
      idx_n = csr_index;
      wdata_n = csr_wdata;
      if (!reset && !start_n && !csr_valid_n && work_q.size() != 0) begin
         if (work_q[0].is_csr) begin
            job = work_q.pop_front();
            csr_valid_n = 1'b1;
            idx_n = job.reg_index;
            wdata_n = job.wdata;
         end else if ($urandom_range(99) >= idle_pct) begin
            job = work_q.pop_front();
            start_n = 1'b1;
            req_n = job.req;
         end
      end
      start <= start_n;
      req_data <= req_n;
      csr_valid <= csr_valid_n;
      csr_index <= idx_n;
      csr_wdata <= wdata_n;
   end

   // monitor and checker
   always @(posedge clock) begin
      bffa_pkg::rsp_type want;
      if (reset) begin
         req_beat <= 1'b0;
         csr_beat <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_grants.size() == 0) begin
               if (faults < REPORT_LIMIT)
                  $display("unexpected grant: number %0h status %0d",
                           rsp_data.allocated_number, rsp_data.status);
               faults++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_data.allocated_number !== want.allocated_number ||
                   rsp_data.status !== want.status) begin
                  if (faults < REPORT_LIMIT)
                     $display("grant mismatch: number %0h status %0d, wanted %0h status %0d",
                              rsp_data.allocated_number, rsp_data.status,
                              want.allocated_number, want.status);
                  faults++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            n_writes++;
            case (csr_index)
               bffa_pkg::CSR_INODE_MAP_SECTORS:  inode_sectors = csr_wdata[2:0];
               bffa_pkg::CSR_SECTOR_MAP_SECTORS: sector_sectors = csr_wdata[3:0];
               bffa_pkg::CSR_FIRST_DATA_SECTOR:  data_base = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            want = predict_grant(req_data);
            expected_grants.push_back(want);
            if (req_data.mode == MODE_SECTOR) n_sector++;
            else n_inode++;
            case (want.status)
               bffa_pkg::STATUS_OK:      n_granted++;
               bffa_pkg::STATUS_FULL:    n_full++;
               bffa_pkg::STATUS_OVERLAP: n_overlap++;
               default: ;
            endcase
         end
         req_beat <= start && !busy;
         csr_beat <= csr_valid && csr_ready;
      end
   end

   initial begin
      logic [23:0] w, base;
      int unsigned isz, ssz, sel, len;
      foreach (inode_map[i]) inode_map[i] = '0;
      foreach (sector_map[i]) sector_map[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: length ignored for inodes, zero run, run from bit 0
      queue_request(MODE_INODE, 0);
      queue_request(MODE_INODE, 16'hFFFF);
      queue_request(MODE_SECTOR, 0);
      queue_request(MODE_SECTOR, 1);
      queue_request(MODE_SECTOR, 3);
      wait_idle();

      // one-sector sector map, empty inode map, largest base
      queue_write(bffa_pkg::CSR_SECTOR_MAP_SECTORS, 24'd1);
      queue_write(bffa_pkg::CSR_FIRST_DATA_SECTOR, 24'hFFFFFF);
      queue_write(bffa_pkg::CSR_INODE_MAP_SECTORS, 24'd0);
      queue_request(MODE_INODE, 0);
      queue_request(MODE_SECTOR, 16'hFFFF);
      queue_request(MODE_SECTOR, 4092);
      queue_request(MODE_SECTOR, 1);
      queue_request(MODE_SECTOR, 0);
      wait_idle();

      // empty sector map, inode size above its maximum
      queue_write(bffa_pkg::CSR_SECTOR_MAP_SECTORS, 24'd0);
      queue_write(bffa_pkg::CSR_INODE_MAP_SECTORS, 24'd7);
      queue_write(bffa_pkg::CSR_FIRST_DATA_SECTOR, 24'd100);
      queue_request(MODE_SECTOR, 1);
      queue_request(MODE_INODE, 0);
      wait_idle();

      // sector size above its maximum, write to the spare index is dropped
      queue_write(bffa_pkg::CSR_SECTOR_MAP_SECTORS, 24'd15);
      queue_write(CSR_SPARE, 24'hA5A5A5);
      queue_request(MODE_SECTOR, 16'h8000);
      queue_request(MODE_SECTOR, 28673);
      queue_request(MODE_SECTOR, 5);
      queue_request(MODE_INODE, 16'h8000);

      for (int p = 0; p < 5; p++) begin
         wait_idle();
         case (p)
            0: begin isz = 4; ssz = 8; base = 24'd1; end
            1: begin isz = 7; ssz = 15; base = 24'hFFFFFF; end
            default: begin
               isz = $urandom_range(7);
               ssz = $urandom_range(15, 2);
               base = 24'($urandom);
            end
         endcase
         // junk in the unused upper bits of the size writes
         w = 24'($urandom);
         w[2:0] = 3'(isz);
         queue_write(bffa_pkg::CSR_INODE_MAP_SECTORS, w);
         w = 24'($urandom);
         w[3:0] = 4'(ssz);
         queue_write(bffa_pkg::CSR_SECTOR_MAP_SECTORS, w);
         queue_write(bffa_pkg::CSR_FIRST_DATA_SECTOR, base);
         idle_pct = (p == 3) ? 0 : 14;
         for (int n = 0; n < 100; n++) begin
            sel = $urandom_range(99);
            if (sel < 8) len = 0;
            else if (sel < 78) len = $urandom_range(16, 1);
            else if (sel < 92) len = $urandom_range(300, 17);
            else len = 16'h8000 | $urandom_range(32767);
            if ($urandom_range(1)) queue_request(MODE_SECTOR, len);
            else queue_request(MODE_INODE, $urandom_range(16'hFFFF));
         end
      end

      wait_idle();
      repeat (64) @(posedge clock);
      $display("covered %0d inode and %0d sector requests over %0d register writes",
               n_inode, n_sector, n_writes);
      $display("outcomes: %0d granted, %0d map full, %0d overlap or past map end",
               n_granted, n_full, n_overlap);
      if (faults == 0 && expected_grants.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #400_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/bffa_pkg.sv
sv/bffa_map.sv
sv/bffa_ctrl.sv
sv/bitmap_first_fit_allocator.sv
tb/sv/bitmap_first_fit_allocator_test.sv
